// ===== sv/ascon_pkg.sv =====
// Shared types and constants for the Ascon 320-bit permutation core.
// Holds the transfer structs, the sequencer states and the round constant helper.
// No dependencies.
package ascon_pkg;

	localparam int unsigned WordWidth = 64;
	localparam int unsigned NumWords  = 5;
	localparam int unsigned RndWidth  = 4;

	// Last round index plus one; a start at or above this applies no round
	localparam logic [RndWidth-1:0] NumRounds = 4'd12;

	typedef logic [NumWords-1:0][WordWidth-1:0] state_t;

	typedef struct packed {
		logic [WordWidth-1:0] word_0;
		logic [WordWidth-1:0] word_1;
		logic [WordWidth-1:0] word_2;
		logic [WordWidth-1:0] word_3;
		logic [WordWidth-1:0] word_4;
		logic [RndWidth-1:0]  start_round;
	} in_item_t;

	typedef struct packed {
		logic [WordWidth-1:0] out_word_0;
		logic [WordWidth-1:0] out_word_1;
		logic [WordWidth-1:0] out_word_2;
		logic [WordWidth-1:0] out_word_3;
		logic [WordWidth-1:0] out_word_4;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	// Round constant: high nibble is 15 - r, low nibble is r
	function automatic logic [7:0] round_const(input logic [RndWidth-1:0] r);
		round_const = {~r, r};
	endfunction

endpackage

// ===== sv/ascon_permutation_core.sv =====
// Ascon 320-bit permutation core: top level with round sequencer and output register.
// Depends on ascon_pkg and ascon_round.
//
// Usage:
//  - Input channel (in_valid / in_ready / in_data) carries five 64-bit state words
//    and a start round 0..15; starts of 12 and above pass the words through.
//  - Output channel (out_valid / out_ready / out_data) carries the permuted words.
//  - One round unit is reused once per cycle; a transfer with start round s runs
//    (12 - s) rounds, then hands over to the output register before the sequencer
//    returns to idle and can accept the next item.
//  - in_ready is high only while the sequencer is idle.
//  - The output register frees the sequencer: a new item may be accepted while a
//    result still waits. If the receiver stalls, the finished state waits in the
//    working register and the sequencer holds until the output register drains.
//  - Reset clears the sequencer and out_valid; no item is in flight afterwards.
module ascon_permutation_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ascon_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ascon_pkg::out_item_t out_data
);

	ascon_pkg::seq_state_t             state_q, state_nxt;
	ascon_pkg::state_t                 work_q;
	ascon_pkg::state_t                 round_out;
	logic [ascon_pkg::RndWidth-1:0]    round_q;
	logic                              out_valid_q;
	ascon_pkg::out_item_t              out_data_q;
	logic                              done;
	logic                              out_free;
	logic                              in_xfer;
	logic                              step;
	logic                              load_out;

	assign done     = (round_q >= ascon_pkg::NumRounds);
	assign out_free = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// shared round unit
	ascon_round u_round (
		.state_in  (work_q),
		.rnd       (round_q),
		.state_out (round_out)
	);

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ascon_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = ascon_pkg::ST_RUN;
			end
			ascon_pkg::ST_RUN: begin
				if (done && out_free) state_nxt = ascon_pkg::ST_IDLE;
			end
			default: state_nxt = ascon_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		step     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ascon_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			ascon_pkg::ST_RUN: begin
				step     = !done;
				load_out = done && out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ascon_pkg::ST_IDLE;
			round_q     <= ascon_pkg::NumRounds;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_xfer) begin
				round_q <= in_data.start_round;
			end else if (step) begin
				round_q <= round_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working state and output payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			work_q[0] <= in_data.word_0;
			work_q[1] <= in_data.word_1;
			work_q[2] <= in_data.word_2;
			work_q[3] <= in_data.word_3;
			work_q[4] <= in_data.word_4;
		end else if (step) begin
			work_q <= round_out;
		end
		if (load_out) begin
			out_data_q.out_word_0 <= work_q[0];
			out_data_q.out_word_1 <= work_q[1];
			out_data_q.out_word_2 <= work_q[2];
			out_data_q.out_word_3 <= work_q[3];
			out_data_q.out_word_4 <= work_q[4];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	// an accepted item blocks the input for at least the next cycle
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input ready one cycle after a transfer");

	// each round step advances the round index by exactly one
	a_round_advance: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (round_q == $past(round_q) + 1'b1))
		else $error("round index did not advance");

	// a result appears only when a finished run is handed over
	a_out_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ascon_pkg::ST_RUN && $past(done)))
		else $error("output loaded outside a finished run");

	// the handover never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while stalled");
`endif

endmodule

// ===== sv/ascon_round.sv =====
// One Ascon round: constant addition, 5-bit substitution layer and linear diffusion.
// Depends on ascon_pkg for the state type and round constant.
module ascon_round (
	input  ascon_pkg::state_t                   state_in,
	input  logic [ascon_pkg::RndWidth-1:0]      rnd,
	output ascon_pkg::state_t                   state_out
);

	function automatic logic [63:0] ror(input logic [63:0] v, input int unsigned n);
		ror = (v >> n) | (v << (64 - n));
	endfunction

	logic [63:0] x2c;
	logic [63:0] a0, a1, a2, a3, a4;
	logic [63:0] t0, t1, t2, t3, t4;
	logic [63:0] n0, n1, n2, n3, n4;

	// constant addition into x2
	assign x2c = state_in[2] ^ {56'd0, ascon_pkg::round_const(rnd)};

	// substitution layer, all 64 slices at once
	always_comb begin
		a0 = state_in[0] ^ state_in[4];
		a4 = state_in[4] ^ state_in[3];
		a2 = x2c ^ state_in[1];
		a1 = state_in[1];
		a3 = state_in[3];

		t0 = a0 ^ (~a1 & a2);
		t1 = a1 ^ (~a2 & a3);
		t2 = a2 ^ (~a3 & a4);
		t3 = a3 ^ (~a4 & a0);
		t4 = a4 ^ (~a0 & a1);

		n0 = t0 ^ t4;
		n1 = t1 ^ t0;
		n2 = ~t2;
		n3 = t3 ^ t2;
		n4 = t4;
	end

	// linear diffusion, one rotation pair per word
	assign state_out[0] = n0 ^ ror(n0, 19) ^ ror(n0, 28);
	assign state_out[1] = n1 ^ ror(n1, 61) ^ ror(n1, 39);
	assign state_out[2] = n2 ^ ror(n2, 1)  ^ ror(n2, 6);
	assign state_out[3] = n3 ^ ror(n3, 10) ^ ror(n3, 17);
	assign state_out[4] = n4 ^ ror(n4, 7)  ^ ror(n4, 41);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ascon_permutation_core: random and directed states and start rounds.
// Depends on ascon_pkg and ascon_permutation_core; predicts each permutation in software.
module tb;

	localparam int unsigned CycleLimit = 500000;
	localparam int unsigned TailCycles = 40;
	localparam int unsigned RandItems  = 1500;
	localparam int unsigned LastRound  = 12;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	ascon_pkg::in_item_t   in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	ascon_pkg::out_item_t  out_data;

	// Pending requests, a flag per request that holds it back until the core drains,
	// and the permuted states still owed by the core
	ascon_pkg::in_item_t   perm_req_q[$];
	bit                    pause_q[$];
	ascon_pkg::out_item_t  permuted_q[$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned send_count     = 0;
	int unsigned recv_count     = 0;
	int unsigned send_wait      = 0;
	int unsigned recv_wait      = 0;

	ascon_permutation_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Rotate right by a fixed non-zero amount
	function automatic logic [63:0] ror64(input logic [63:0] v, input int unsigned n);
		ror64 = (v >> n) | (v << (64 - n));
	endfunction

	// Rounds from the start index through the last one; starts of twelve and up pass through
	function automatic ascon_pkg::out_item_t ascon_permute(input ascon_pkg::in_item_t req);
		ascon_pkg::state_t     s;
		logic [63:0]           a0, a1, a2, a3, a4;
		logic [63:0]           n0, n1, n2, n3, n4;
		logic [3:0]            rnd4;
		ascon_pkg::out_item_t  res;
		s[0] = req.word_0;
		s[1] = req.word_1;
		s[2] = req.word_2;
		s[3] = req.word_3;
		s[4] = req.word_4;
		for (int unsigned rnd = req.start_round; rnd < LastRound; rnd++) begin
			rnd4 = 4'(rnd);
			s[2] ^= {56'd0, 4'(4'd15 - rnd4), rnd4};
			// substitution across bit slices
			a0 = s[0] ^ s[4];
			a4 = s[4] ^ s[3];
			a2 = s[2] ^ s[1];
			a1 = s[1];
			a3 = s[3];
			n0 = a0 ^ (~a1 & a2);
			n1 = a1 ^ (~a2 & a3);
			n2 = a2 ^ (~a3 & a4);
			n3 = a3 ^ (~a4 & a0);
			n4 = a4 ^ (~a0 & a1);
			n1 ^= n0;
			n0 ^= n4;
			n3 ^= n2;
			n2 = ~n2;
			// linear diffusion per word
			s[0] = n0 ^ ror64(n0, 19) ^ ror64(n0, 28);
			s[1] = n1 ^ ror64(n1, 61) ^ ror64(n1, 39);
			s[2] = n2 ^ ror64(n2, 1)  ^ ror64(n2, 6);
			s[3] = n3 ^ ror64(n3, 10) ^ ror64(n3, 17);
			s[4] = n4 ^ ror64(n4, 7)  ^ ror64(n4, 41);
		end
		res.out_word_0 = s[0];
		res.out_word_1 = s[1];
		res.out_word_2 = s[2];
		res.out_word_3 = s[3];
		res.out_word_4 = s[4];
		return res;
	endfunction

	// Mostly dense random words, with some all-zero, all-one and single-bit words
	function automatic logic [63:0] rand_word();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		case (pick)
			0:       return '0;
			1:       return '1;
			2:       return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Idle cycles before the next transfer on one side; none during quiet stretches
	function automatic int unsigned draw_wait(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 7);
	endfunction

	task automatic queue_perm(input logic [63:0] w0, input logic [63:0] w1,
	                          input logic [63:0] w2, input logic [63:0] w3,
	                          input logic [63:0] w4, input logic [3:0] start, input bit hold);
		ascon_pkg::in_item_t req;
		req.word_0      = w0;
		req.word_1      = w1;
		req.word_2      = w2;
		req.word_3      = w3;
		req.word_4      = w4;
		req.start_round = start;
		perm_req_q.push_back(req);
		pause_q.push_back(hold);
	endtask

	// Clock
	initial begin
		forever #1 clk = ~clk;
	end

	// Input driver: records each accepted transfer and presents the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			send_wait = 0;
		end else begin
			if (in_valid && in_ready) begin
				permuted_q.push_back(ascon_permute(in_data));
				send_count++;
				send_wait = draw_wait((send_count % 200) < 40);
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (perm_req_q.size() > 0 &&
				             !(pause_q[0] && permuted_q.size() > 0)) begin
					in_valid <= 1'b1;
					in_data  <= perm_req_q.pop_front();
					void'(pause_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		ascon_pkg::out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				recv_count++;
				if (permuted_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("tb: result with nothing expected: %h", out_data);
				end else begin
					want = permuted_q.pop_front();
					if (out_data.out_word_0 !== want.out_word_0 ||
					    out_data.out_word_1 !== want.out_word_1 ||
					    out_data.out_word_2 !== want.out_word_2 ||
					    out_data.out_word_3 !== want.out_word_3 ||
					    out_data.out_word_4 !== want.out_word_4) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("tb: mismatch on result %0d\n  expected %h %h %h %h %h\n  actual   %h %h %h %h %h",
							         recv_count, want.out_word_0, want.out_word_1,
							         want.out_word_2, want.out_word_3, want.out_word_4,
							         out_data.out_word_0, out_data.out_word_1,
							         out_data.out_word_2, out_data.out_word_3,
							         out_data.out_word_4);
					end
				end
				recv_wait = draw_wait((recv_count % 250) >= 200);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Stimulus, reset and end of run
	initial begin
		// extremes of the words, full permutations and one partial from round six
		queue_perm('0, '0, '0, '0, '0, 4'd0, 1'b0);
		queue_perm('1, '1, '1, '1, '1, 4'd0, 1'b0);
		queue_perm({16{4'hA}}, {16{4'h5}}, {16{4'hA}}, {16{4'h5}}, {16{4'hA}}, 4'd0, 1'b0);
		queue_perm({16{4'h5}}, {16{4'hA}}, {16{4'h5}}, {16{4'hA}}, {16{4'h5}}, 4'd6, 1'b0);
		// every start index, including twelve and the out-of-range starts that pass through
		for (int unsigned st = 0; st < 16; st++)
			queue_perm(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
			           4'(st), 1'b0);
		queue_perm('0, '0, '0, '0, '0, 4'd12, 1'b0);
		queue_perm('1, '1, '1, '1, '1, 4'd15, 1'b0);
		queue_perm('1, '1, '1, '1, '1, 4'd11, 1'b0);

		// random part; a few requests wait for the core to drain completely
		for (int unsigned k = 0; k < RandItems; k++) begin
			logic [3:0] start;
			int unsigned pick;
			pick = $urandom_range(0, 9);
			if (pick < 3)
				start = 4'd0;
			else if (pick < 9)
				start = 4'($urandom_range(0, 12));
			else
				start = 4'($urandom_range(0, 15));
			queue_perm(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
			           start, (k % 400) == 0);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (perm_req_q.size() > 0 || in_valid || permuted_q.size() > 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		if (mismatch_count == 0 && permuted_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
